[design/four_level_page_table_mapper_assert.svh]
// Assertion macros for the page-table mapper
`ifndef FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_MAPPER_ASSERT_SVH
// implication checked every clock edge outside reset
`define FLPT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define FLPT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

[design/flptm_pkg.sv]
// ---------------------------------------------------------------------------
// flptm_pkg
// Types and constants shared by the four-level page-table mapper.
// ---------------------------------------------------------------------------
`default_nettype none
package flptm_pkg;
   localparam int TableFrames = 16;
   localparam int FrameBits = (TableFrames > 1) ? $clog2(TableFrames) : 1;
   localparam int FrameCntBits = $clog2(TableFrames + 1);
   localparam int Entries = 512;
   localparam int IdxBits = 9;
   localparam int AddrBits = FrameBits + IdxBits;
   localparam int Depth = TableFrames * Entries;

   localparam logic [1:0] ACT_LOOKUP = 2'd0;
   localparam logic [1:0] ACT_MAP = 2'd1;
   localparam logic [1:0] ACT_UNMAP = 2'd2;
   localparam logic [1:0] ACT_NONE = 2'd3;

   localparam logic [63:0] BIT_P = 64'h1;
   localparam logic [63:0] BIT_RW = 64'h2;
   localparam logic [63:0] BIT_U = 64'h4;

   typedef struct packed {
      logic [1:0] action;
      logic [35:0] virt_page;
      logic [39:0] phys_page;
      logic [11:0] page_count;
   } req_type;

   typedef struct packed {
      logic status;
      logic is_present;
      logic [63:0] lead_entry;
   } rsp_type;

   typedef enum logic {
      CSR_TABLE_BASE = 1'b0,
      CSR_ROOT_FRAME = 1'b1
   } csr_index_type;
endpackage
`default_nettype wire

[design/four_level_page_table_mapper.sv]
// ---------------------------------------------------------------------------
// four_level_page_table_mapper
// Walks and edits a pool of four-level page tables held in one RAM.
// ---------------------------------------------------------------------------
// One item at a time. After reset the table RAM is swept clear, one entry a
// cycle (TableFrames*512 = 8192 entries), before the first request beat is
// taken. Each table level passes through a RAM read state (ST_READ) and an
// evaluate state (ST_EVAL). A lookup or unmap walk that meets an absent level
// stops there; a map instead takes a fresh frame, clears its 512 entries in
// ST_WIPE and links it into the parent slot in ST_LINK. An empty run or an
// unknown action skips the walk. The response beat is raised from ST_DONE
// and req_ready stays low until it is taken; the next request beat is taken
// at the earliest in the cycle after the response beat. The table RAM read is
// registered.
`default_nettype none
`include "four_level_page_table_mapper_assert.svh"
module four_level_page_table_mapper (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire flptm_pkg::req_type req_data,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output flptm_pkg::rsp_type rsp_data,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [0:0] csr_index,
   input  wire logic [63:0] csr_data
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_EVAL = 3'd3;
   localparam logic [2:0] ST_WIPE = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;
   localparam logic [2:0] ST_LINK = 3'd6;

   logic [63:0] mem [flptm_pkg::Depth];
   logic [63:0] rd_ff;

   logic [2:0] state_ff, state_in;
   logic [flptm_pkg::AddrBits-1:0] clr_ff, clr_in;
   logic [39:0] base_ff, base_in;
   logic [3:0] root_ff, root_in;
   logic [flptm_pkg::FrameCntBits-1:0] nfree_ff, nfree_in;
   flptm_pkg::req_type req_ff, req_in;
   logic [11:0] cnt_ff, cnt_in;
   logic [35:0] vp_ff, vp_in;
   logic [39:0] pp_ff, pp_in;
   logic [1:0] lvl_ff, lvl_in;
   logic [flptm_pkg::FrameBits-1:0] frm_ff, frm_in;
   logic [flptm_pkg::FrameBits-1:0] wfrm_ff, wfrm_in;
   logic user_ff, user_in;
   logic first_ff, first_in;
   flptm_pkg::rsp_type out_ff, out_in;
   logic ov_ff, ov_in;

   logic we;
   logic [flptm_pkg::AddrBits-1:0] waddr, raddr;
   logic [63:0] wdata;
   logic [8:0] idx;
   logic [39:0] diff;
   logic child_ok;
   logic [flptm_pkg::FrameBits-1:0] child;
   logic [flptm_pkg::FrameBits-1:0] nf_frame;
   logic [flptm_pkg::FrameBits-1:0] root_frm;
   logic [63:0] leaf, tentry;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   always_comb begin
      case (lvl_ff)
         2'd3: idx = vp_ff[35:27];
         2'd2: idx = vp_ff[26:18];
         2'd1: idx = vp_ff[17:9];
         default: idx = vp_ff[8:0];
      endcase
      raddr = {frm_ff, idx};
      diff = rd_ff[51:12] - base_ff;
      child_ok = rd_ff[0] && (diff < 40'(flptm_pkg::TableFrames));
      child = diff[flptm_pkg::FrameBits-1:0];
      nf_frame = nfree_ff[flptm_pkg::FrameBits-1:0];
      root_frm = flptm_pkg::FrameBits'(32'(root_ff) % 32'(flptm_pkg::TableFrames));
      leaf = {12'd0, pp_ff, 12'd0} | flptm_pkg::BIT_P | flptm_pkg::BIT_RW
         | (user_ff ? flptm_pkg::BIT_U : 64'd0);
      tentry = {12'd0, 40'(base_ff + 40'(wfrm_ff)), 12'd0} | flptm_pkg::BIT_P
         | flptm_pkg::BIT_RW | (user_ff ? flptm_pkg::BIT_U : 64'd0);
   end

   assign req_ready = (state_ff == ST_IDLE) && !ov_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = ov_ff;
   assign rsp_data = out_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      base_in = base_ff;
      root_in = root_ff;
      nfree_in = nfree_ff;
      req_in = req_ff;
      cnt_in = cnt_ff;
      vp_in = vp_ff;
      pp_in = pp_ff;
      lvl_in = lvl_ff;
      frm_in = frm_ff;
      wfrm_in = wfrm_ff;
      user_in = user_ff;
      first_in = first_ff;
      out_in = out_ff;
      ov_in = ov_ff && !rsp_ready;
      we = 1'b0;
      waddr = clr_ff;
      wdata = 64'd0;
      if (csr_valid) begin
         if (csr_index == 1'(flptm_pkg::CSR_TABLE_BASE)) begin
            base_in = csr_data[39:0];
         end else begin
            root_in = csr_data[3:0];
         end
      end
      case (state_ff)
         ST_CLEAR: begin
            we = 1'b1;
            clr_in = clr_ff + flptm_pkg::AddrBits'(1);
            if (clr_ff == flptm_pkg::AddrBits'(flptm_pkg::Depth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_data;
               vp_in = req_data.virt_page;
               pp_in = req_data.phys_page;
               cnt_in = (req_data.action == flptm_pkg::ACT_LOOKUP) ? 12'd1
                  : req_data.page_count;
               user_in = !req_data.virt_page[35];
               first_in = 1'b1;
               out_in = '0;
               lvl_in = 2'd3;
               frm_in = root_frm;
               if (req_data.action == flptm_pkg::ACT_NONE || req_data.page_count == 12'd0
                     && req_data.action != flptm_pkg::ACT_LOOKUP) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_READ;
            if (lvl_ff == 2'd0) begin
               case (req_ff.action)
                  flptm_pkg::ACT_LOOKUP: out_in.is_present = rd_ff[0];
                  flptm_pkg::ACT_MAP: begin
                     we = 1'b1;
                     waddr = raddr;
                     wdata = leaf;
                     if (first_ff) begin
                        out_in.lead_entry = leaf;
                     end
                  end
                  default: begin
                     we = 1'b1;
                     waddr = raddr;
                  end
               endcase
               first_in = 1'b0;
               cnt_in = cnt_ff - 12'd1;
               vp_in = vp_ff + 36'd1;
               pp_in = pp_ff + 40'd1;
               lvl_in = 2'd3;
               frm_in = root_frm;
               if (cnt_ff == 12'd1) begin
                  state_in = ST_DONE;
               end
            end else if (child_ok) begin
               if (req_ff.action == flptm_pkg::ACT_MAP && user_ff) begin
                  we = 1'b1;
                  waddr = raddr;
                  wdata = rd_ff | flptm_pkg::BIT_U;
               end
               frm_in = child;
               lvl_in = lvl_ff - 2'd1;
            end else if (req_ff.action != flptm_pkg::ACT_MAP) begin
               if (req_ff.action == flptm_pkg::ACT_LOOKUP) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff - 12'd1;
                  vp_in = vp_ff + 36'd1;
                  lvl_in = 2'd3;
                  frm_in = root_frm;
                  if (cnt_ff == 12'd1) begin
                     state_in = ST_DONE;
                  end
               end
            end else if (nfree_ff >= flptm_pkg::FrameCntBits'(flptm_pkg::TableFrames)) begin
               out_in.status = 1'b1;
               out_in.lead_entry = 64'd0;
               state_in = ST_DONE;
            end else begin
               wfrm_in = nf_frame;
               nfree_in = nfree_ff + flptm_pkg::FrameCntBits'(1);
               clr_in = {nf_frame, 9'd0};
               state_in = ST_WIPE;
            end
         end
         ST_WIPE: begin
            we = 1'b1;
            waddr = clr_ff;
            clr_in = clr_ff + flptm_pkg::AddrBits'(1);
            if (clr_ff[8:0] == 9'h1FF) begin
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            // parent slot is written after the wipe, the new frame may hold it
            we = 1'b1;
            waddr = raddr;
            wdata = tentry;
            frm_in = wfrm_ff;
            lvl_in = lvl_ff - 2'd1;
            state_in = ST_READ;
         end
         ST_DONE: begin
            if (!ov_ff) begin
               ov_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         base_ff <= '0;
         root_ff <= '0;
         nfree_ff <= flptm_pkg::FrameCntBits'(1);
         ov_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         base_ff <= base_in;
         root_ff <= root_in;
         nfree_ff <= nfree_in;
         ov_ff <= ov_in;
      end
      req_ff <= req_in;
      cnt_ff <= cnt_in;
      vp_ff <= vp_in;
      pp_ff <= pp_in;
      lvl_ff <= lvl_in;
      frm_ff <= frm_in;
      wfrm_ff <= wfrm_in;
      user_ff <= user_in;
      first_ff <= first_in;
      out_ff <= out_in;
   end

   `FLPT_ASSERT_IMP(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_ready, "accept while busy")
   `FLPT_ASSERT_NXT(a_alloc_bounded, clock, reset, state_ff == ST_WIPE, nfree_ff <= flptm_pkg::FrameCntBits'(flptm_pkg::TableFrames), "allocator overrun")
   `FLPT_ASSERT_IMP(a_fail_zero, clock, reset, ov_ff && out_ff.status, out_ff.lead_entry == 64'd0, "failure with entry")
endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the four-level page-table mapper. A local copy of
// the table pool predicts every response. Phases under several base-page and
// root settings mix directed edge cases with clustered random map, unmap and
// lookup traffic.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
   import flptm_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CSR_TABLE_BASE;
   logic [63:0] csr_data = '0;

   four_level_page_table_mapper i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #40_000_000;
      $display("FAIL four_level_page_table_mapper");
      $finish;
   end

   // shadow of the table pool
   logic [63:0] pool [0:Depth-1];
   int unsigned alloc_next;
   logic [39:0] base_page;
   logic [3:0] root_sel;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   logic [35:0] mapped_pages [$];
   logic [35:0] regions [4];
   int unsigned fail_count = 0;
   int unsigned req_gap = 0;
   bit no_idle = 1'b0;

   function automatic bit entry_frame(logic [63:0] e, output int unsigned f);
      logic [39:0] d;
      d = e[51:12] - base_page;
      f = d[3:0];
      return e[0] && (d < TableFrames);
   endfunction

   function automatic bit descend(int unsigned parent, logic [8:0] idx, bit user,
                                  output int unsigned child);
      int unsigned slot, f;
      logic [39:0] pg;
      slot = parent * Entries + idx;
      child = 0;
      if (entry_frame(pool[slot], f)) begin
         if (user) pool[slot] |= BIT_U;
         child = f;
         return 1'b1;
      end
      if (alloc_next >= TableFrames) return 1'b0;
      f = alloc_next;
      alloc_next++;
      for (int k = 0; k < Entries; k++) pool[f * Entries + k] = '0;
      pg = base_page + 40'(f);
      pool[slot] = {12'h0, pg, 12'h0} | BIT_P | BIT_RW | (user ? BIT_U : 64'h0);
      child = f;
      return 1'b1;
   endfunction

   function automatic bit leaf_slot(logic [35:0] vp, output int unsigned slot);
      int unsigned f, nf;
      f = root_sel % TableFrames;
      slot = 0;
      for (int lvl = 3; lvl >= 1; lvl--) begin
         if (!entry_frame(pool[f * Entries + vp[9*lvl +: 9]], nf)) return 1'b0;
         f = nf;
      end
      slot = f * Entries + vp[8:0];
      return 1'b1;
   endfunction

   function automatic void predict_walk(req_type r);
      rsp_type e;
      logic [35:0] vp;
      logic [39:0] pp;
      int unsigned f, nf, slot;
      bit user, ok;
      e = '0;
      case (r.action)
         ACT_LOOKUP: begin
            if (leaf_slot(r.virt_page, slot) && pool[slot][0]) e.is_present = 1'b1;
         end
         ACT_MAP: begin
            user = !r.virt_page[35];
            for (int i = 0; i < r.page_count; i++) begin
               vp = r.virt_page + 36'(i);
               pp = r.phys_page + 40'(i);
               f = root_sel % TableFrames;
               ok = 1'b1;
               for (int lvl = 3; lvl >= 1; lvl--) begin
                  if (!descend(f, vp[9*lvl +: 9], user, nf)) begin
                     ok = 1'b0;
                     break;
                  end
                  f = nf;
               end
               if (!ok) begin
                  e.status = 1'b1;
                  e.lead_entry = '0;
                  break;
               end
               slot = f * Entries + vp[8:0];
               pool[slot] = {12'h0, pp, 12'h0} | BIT_P | BIT_RW | (user ? BIT_U : 64'h0);
               if (i == 0) e.lead_entry = pool[slot];
            end
         end
         ACT_UNMAP: begin
            for (int i = 0; i < r.page_count; i++) begin
               vp = r.virt_page + 36'(i);
               if (leaf_slot(vp, slot)) pool[slot] = '0;
            end
         end
         default: ;
      endcase
      expected_rsps.push_back(e);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic req_type make_req(logic [1:0] act, logic [35:0] vp,
                                        logic [39:0] pp, logic [11:0] cnt);
      req_type r;
      r.action = act;
      r.virt_page = vp;
      r.phys_page = pp;
      r.page_count = cnt;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      r.action = (sel < 35) ? ACT_LOOKUP : (sel < 70) ? ACT_MAP :
                 (sel < 95) ? ACT_UNMAP : ACT_NONE;
      r.phys_page = {8'($urandom), 32'($urandom)};
      sel = $urandom_range(0, 99);
      if (sel < 60)
         r.virt_page = regions[$urandom_range(0, 3)] + 36'($urandom_range(0, 1023));
      else if (sel < 80 && mapped_pages.size() > 0)
         r.virt_page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      else
         r.virt_page = {4'($urandom), 32'($urandom)};
      sel = $urandom_range(0, 99);
      r.page_count = (sel < 85) ? 12'($urandom_range(0, 6)) :
                     (sel < 99) ? 12'($urandom_range(7, 40)) : 12'($urandom_range(0, 4095));
      if (r.action == ACT_MAP) mapped_pages.push_back(r.virt_page);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_walk(req_data);
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               req_gap <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected response beat %p", rsp_data);
            end else if (rsp_data !== expected_rsps[0]) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("mismatch: status exp %0d got %0d, present exp %0d got %0d",
                           expected_rsps[0].status, rsp_data.status,
                           expected_rsps[0].is_present, rsp_data.is_present,
                           ", entry exp %h got %h",
                           expected_rsps[0].lead_entry, rsp_data.lead_entry);
               void'(expected_rsps.pop_front());
            end else begin
               void'(expected_rsps.pop_front());
            end
         end
         rsp_ready <= (pick_gap() == 0);
      end
   end

   task automatic wait_idle();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_TABLE_BASE) base_page = value[39:0];
      else root_sel = value[3:0];
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [39:0] bases [5];
      logic [3:0] roots [5];
      for (int k = 0; k < Depth; k++) pool[k] = '0;
      alloc_next = 1;
      base_page = '0;
      root_sel = '0;
      regions = '{36'h0_0000_0000, 36'h7_FFFF_FE00, 36'h8_0000_0000, 36'hF_FFFF_FC00};
      bases = '{40'hFF_FFFF_FFFD, 40'h0, 40'h12_3456_789A, 40'hFF_FFFF_FFFD, 40'h0};
      roots = '{4'd0, 4'd0, 4'd15, 4'd0, 4'd7};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 5; ph++) begin
         write_reg(CSR_TABLE_BASE, {24'($urandom), bases[ph]});
         write_reg(CSR_ROOT_FRAME, {60'($urandom), roots[ph]});
         no_idle = ($urandom_range(0, 3) == 0);
         if (ph == 0) begin
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0000_0000, '0, 12'd1));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h0_0000_0000, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h0_0000_0010, '0, 12'd3));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0000_0011, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h8_0000_0000,
                                            40'hFF_FFFF_FFFE, 12'd3));
            pending_reqs.push_back(make_req(ACT_MAP, 36'hF_FFFF_FFFE,
                                            40'hFF_FFFF_FFFF, 12'd4));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h0_0000_0001,
                                            40'h00_0000_1234, 12'd1));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0000_0000, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'hF_FFFF_FFFF, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h7_FFFF_FFFF,
                                            40'hFF_FFFF_FFFF, 12'd2));
            pending_reqs.push_back(make_req(ACT_UNMAP, 36'hF_FFFF_FFFF, '0, 12'd3));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0000_0000, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_NONE, 36'hF_FFFF_FFFF,
                                            40'hFF_FFFF_FFFF, 12'hFFF));
            pending_reqs.push_back(make_req(ACT_UNMAP, 36'h0_0000_0000, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_MAP, 36'h0_0004_0000,
                                            40'h55_5555_5555, 12'hFFF));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0004_0FFE, '0, 12'd0));
            pending_reqs.push_back(make_req(ACT_UNMAP, 36'h0_0004_0000, '0, 12'hFFF));
            pending_reqs.push_back(make_req(ACT_LOOKUP, 36'h0_0004_0FFE, '0, 12'd0));
            for (int k = 0; k < 24; k++)
               pending_reqs.push_back(make_req(ACT_MAP, {4'($urandom), 32'($urandom)},
                                               {8'($urandom), 32'($urandom)}, 12'd1));
         end
         for (int k = 0; k < 390; k++) pending_reqs.push_back(random_req());
         wait_idle();
      end
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS four_level_page_table_mapper");
      end else begin
         $display("FAIL four_level_page_table_mapper");
      end
      $finish;
   end
endmodule
`default_nettype wire
